>>> rtl/i2cbe_pkg.sv
// Shared types and constants for the I2C master bit engine.
package i2cbe_pkg;

    localparam int TICK_COUNT_BITS_DEF = 16;
    localparam int HALF_PERIOD_W       = 16;
    localparam int BYTE_W              = 8;
    localparam int IN_TDATA_W          = 16;
    localparam int OUT_TDATA_W         = 16;

    localparam logic [HALF_PERIOD_W-1:0] HALF_PERIOD_RST = HALF_PERIOD_W'(1);
    localparam logic [3:0]               BITS_PER_BYTE   = 4'd8;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_STOP  = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    // Line levels for one segment: scl then sda, 1 means released.
    typedef struct packed {
        logic scl;
        logic sda;
    } lines_t;

endpackage

>>> rtl/i2c_master_bit_engine_top.sv
// I2C master bit engine: one input word per timing tick, one result word per input word.
// Each result word is registered in the output register, or in the skid entry on a stall.
// Throughput: one word per cycle while the skid entry is empty; the state update is one pass
// from the state registers to the result register; a one-entry skid absorbs a master stall.
// Reset: rst_n clears the engine to idle with SCL and SDA released, the half period to one
// tick, the read byte and acknowledge flag to zero, and both output stages to empty.
module i2c_master_bit_engine_top
    import i2cbe_pkg::*;
#(
    parameter int TICK_COUNT_BITS = TICK_COUNT_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // configuration: half_period_ticks
    input  logic                     cfg_we,
    input  logic [HALF_PERIOD_W-1:0] cfg_data,
    // slave side
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // [0] cmd_valid, [8:1] write_data, [9] send_ack, [10] sda_sense, [15:11] zero
    input  logic [IN_TDATA_W-1:0]    s_axis_tdata,
    // [1:0] op
    input  logic [1:0]               s_axis_tuser,
    // master side
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // [0] scl_level, [1] sda_drive, [2] busy_res, [3] done_res, [11:4] read_data,
    // [12] ack_missing, [15:13] zero
    output logic [OUT_TDATA_W-1:0]   m_axis_tdata
);

    localparam int TCB = TICK_COUNT_BITS;
    localparam int PW  = ((TCB > HALF_PERIOD_W) ? TCB : HALF_PERIOD_W) + 1;

    // engine state
    logic [HALF_PERIOD_W-1:0] half_period_reg;
    logic [TCB-1:0]           tick_count_reg, tick_count_next;
    logic [3:0]               bit_index_reg, bit_index_next;
    logic [1:0]               sub_phase_reg, sub_phase_next;
    logic [BYTE_W-1:0]        shift_reg, shift_next;
    op_t                      cmd_reg, cmd_next;
    logic                     ack_choice_reg, ack_choice_next;
    logic                     nack_reg, nack_next;
    logic                     active_reg, active_next;
    logic                     scl_reg, scl_next;
    logic                     sda_reg, sda_next;
    logic [BYTE_W-1:0]        read_hold_reg, read_hold_next;
    logic                     done_next;

    // output stages
    logic                     out_valid_reg;
    logic [OUT_TDATA_W-1:0]   out_data_reg;
    logic                     skid_valid_reg;
    logic [OUT_TDATA_W-1:0]   skid_data_reg;

    logic                     accept;
    logic                     out_free;
    logic [OUT_TDATA_W-1:0]   result;

    // input fields
    logic                     in_cmd_valid;
    op_t                      in_op;
    logic [BYTE_W-1:0]        in_write_data;
    logic                     in_send_ack;
    logic                     in_sense;

    // half period handling
    logic [PW-1:0]            hp_ext;
    logic [PW-1:0]            hp_limit;
    logic [PW-1:0]            hp_eff;
    logic [PW-1:0]            tick_inc;
    logic                     seg_end;
    logic                     finish;
    lines_t                   lines;

    assign in_cmd_valid  = s_axis_tdata[0];
    assign in_write_data = s_axis_tdata[8:1];
    assign in_send_ack   = s_axis_tdata[9];
    assign in_sense      = s_axis_tdata[10];
    assign in_op         = op_t'(s_axis_tuser);

    assign s_axis_tready = !skid_valid_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Clamp the period to 1..2^TCB ticks.
    assign hp_ext   = PW'(half_period_reg);
    assign hp_limit = PW'(1) << TCB;
    always_comb
    begin
        priority if (hp_ext == '0)
            hp_eff = PW'(1);
        else if (hp_ext > hp_limit)
            hp_eff = hp_limit;
        else
            hp_eff = hp_ext;
    end

    assign tick_inc = PW'(tick_count_reg) + PW'(1);
    assign seg_end  = (tick_inc >= hp_eff);

    // Line levels of the segment given by the command position.
    function automatic lines_t drive_lines(input op_t cmd, input logic [1:0] sub,
                                           input logic [3:0] bidx, input logic msb,
                                           input logic ack, input lines_t cur);
        lines_t l;
        l = cur;
        unique case (cmd)
            OP_START:
            begin
                l.sda = (sub == 2'd0);
                l.scl = (sub != 2'd2);
            end
            OP_STOP:
            begin
                l.sda = (sub == 2'd2);
                if (sub != 2'd0)
                    l.scl = 1'b1;
            end
            OP_WRITE, OP_READ:
            begin
                if (bidx < BITS_PER_BYTE)
                begin
                    if (sub == 2'd0)
                    begin
                        l.scl = 1'b0;
                        l.sda = (cmd == OP_WRITE) ? msb : 1'b1;
                    end
                    else
                        l.scl = 1'b1;
                end
                else
                begin
                    if (sub == 2'd0)
                    begin
                        l.scl = 1'b0;
                        l.sda = (cmd == OP_WRITE) ? 1'b1 : !ack;
                    end
                    else
                        l.scl = (sub == 2'd1);
                end
            end
            default: l = cur;
        endcase
        return l;
    endfunction

    always_comb
    begin
        tick_count_next = tick_count_reg;
        bit_index_next  = bit_index_reg;
        sub_phase_next  = sub_phase_reg;
        shift_next      = shift_reg;
        cmd_next        = cmd_reg;
        ack_choice_next = ack_choice_reg;
        nack_next       = nack_reg;
        active_next     = active_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        read_hold_next  = read_hold_reg;
        done_next       = 1'b0;
        finish          = 1'b0;
        lines           = '{scl: scl_reg, sda: sda_reg};

        if (active_reg)
        begin
            if (seg_end)
            begin
                tick_count_next = '0;
                if (cmd_reg == OP_START || cmd_reg == OP_STOP)
                begin
                    sub_phase_next = sub_phase_reg + 2'd1;
                    finish         = (sub_phase_reg == 2'd2);
                end
                else if (bit_index_reg < BITS_PER_BYTE)
                begin
                    if (sub_phase_reg == 2'd0)
                        sub_phase_next = 2'd1;
                    else
                    begin
                        // shift out the sent bit, or shift in the sampled one
                        shift_next = (cmd_reg == OP_WRITE) ? {shift_reg[BYTE_W-2:0], 1'b0}
                                                           : {shift_reg[BYTE_W-2:0], in_sense};
                        bit_index_next = bit_index_reg + 4'd1;
                        sub_phase_next = 2'd0;
                    end
                end
                else
                begin
                    if (sub_phase_reg == 2'd1 && cmd_reg == OP_WRITE)
                        nack_next = in_sense;
                    sub_phase_next = sub_phase_reg + 2'd1;
                    finish         = (sub_phase_reg == 2'd2);
                end

                if (finish)
                begin
                    active_next    = 1'b0;
                    done_next      = 1'b1;
                    bit_index_next = '0;
                    sub_phase_next = '0;
                    if (cmd_reg == OP_READ)
                    begin
                        read_hold_next = shift_next;
                        sda_next       = 1'b1;
                    end
                end
                else
                begin
                    lines    = drive_lines(cmd_reg, sub_phase_next, bit_index_next,
                                           shift_next[BYTE_W-1], ack_choice_reg, lines);
                    scl_next = lines.scl;
                    sda_next = lines.sda;
                end
            end
            else
                tick_count_next = tick_inc[TCB-1:0];
        end
        else if (in_cmd_valid)
        begin
            cmd_next        = in_op;
            ack_choice_next = in_send_ack;
            shift_next      = (in_op == OP_WRITE) ? in_write_data : '0;
            bit_index_next  = '0;
            sub_phase_next  = '0;
            tick_count_next = '0;
            active_next     = 1'b1;
            lines           = drive_lines(in_op, 2'd0, 4'd0, in_write_data[BYTE_W-1],
                                          in_send_ack, lines);
            scl_next        = lines.scl;
            sda_next        = lines.sda;
        end
    end

    assign result = {3'b000, nack_next, read_hold_next, done_next, active_next,
                     sda_next, scl_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= HALF_PERIOD_RST;
            tick_count_reg  <= '0;
            bit_index_reg   <= '0;
            sub_phase_reg   <= '0;
            shift_reg       <= '0;
            cmd_reg         <= OP_START;
            ack_choice_reg  <= 1'b0;
            nack_reg        <= 1'b0;
            active_reg      <= 1'b0;
            scl_reg         <= 1'b1;
            sda_reg         <= 1'b1;
            read_hold_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
                half_period_reg <= cfg_data;
            if (accept)
            begin
                tick_count_reg <= tick_count_next;
                bit_index_reg  <= bit_index_next;
                sub_phase_reg  <= sub_phase_next;
                shift_reg      <= shift_next;
                cmd_reg        <= cmd_next;
                ack_choice_reg <= ack_choice_next;
                nack_reg       <= nack_next;
                active_reg     <= active_next;
                scl_reg        <= scl_next;
                sda_reg        <= sda_next;
                read_hold_reg  <= read_hold_next;
            end
        end
    end

    // Output register with one skid entry; the skid drains before new words land.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= accept;
        end
        else if (accept)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (accept)
                out_data_reg <= result;
        end
        else if (accept)
            skid_data_reg <= result;
    end

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_idle_position: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> (bit_index_reg == '0 && sub_phase_reg == '0))
        else $error("idle engine left with a bit position");

    a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_index_reg <= BITS_PER_BYTE)
        else $error("bit index beyond the acknowledge slot");

    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && done_next) |=> !active_reg)
        else $error("engine still busy after finishing a command");

    a_read_released: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && done_next && cmd_reg == OP_READ) |=> sda_reg)
        else $error("SDA not released after a read");

endmodule
